[sv/wanm_pkg.sv]
// Package with the shared types, constants and character helpers of the name matcher.
`timescale 1ns / 1ps
package wanm_pkg;

    localparam int DEF_MAX_ENTRIES = 512;
    localparam int DEF_NAME_CHARS  = 64;
    localparam int DEF_QUERY_CHARS = 64;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;
    localparam int MATCH_W    = 13;
    localparam int LOADED_W   = 10;
    localparam int NUM_W      = 12;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_CASE_OFS = 8'h20;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic signed [MATCH_W-1:0] NO_MATCH = -13'sd1;

    typedef enum logic [1:0] {
        MODE_NAME  = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_ENT,
        S_P1_RD,
        S_P1_EV,
        S_SKIP_RD,
        S_SKIP_EV,
        S_CMP_RD,
        S_CMP_EV,
        S_NEND_RD,
        S_NEND_EV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic start_scan;
        logic ent_next;
        logic clr_ptr;
        logic inc_n;
        logic inc_q;
        logic set_hit;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic cnt_empty;
        logic ent_last;
        logic q_empty;
        logic nend;
        logic qend;
        logic nbl;
        logic qbl;
        logic eq;
        logic out_free;
    } t_stat;

    function automatic logic [7:0] fold(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CH_CASE_OFS : c;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

[sv/wanm_ctrl.sv]
// Controller state machine that sequences loading and the table scan.
`timescale 1ns / 1ps
module wanm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_last,
    input  logic [1:0]      i_mode,
    input  wanm_pkg::t_stat i_stat,
    output logic            o_ready,
    output wanm_pkg::t_cmd  o_cmd
);
    import wanm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                o_cmd.accept = i_valid;
                if (i_valid && i_last && t_mode'(i_mode) == MODE_QUERY) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.start_scan = 1'b1;
                n_state = S_ENT;
            end
            S_ENT: begin
                if (i_stat.cnt_empty) begin
                    n_state = S_DONE;
                end else if (i_stat.q_empty) begin
                    n_state = S_SKIP_RD;
                end else begin
                    n_state = S_P1_RD;
                end
            end
            S_P1_RD:   n_state = S_P1_EV;
            S_SKIP_RD: n_state = S_SKIP_EV;
            S_CMP_RD:  n_state = S_CMP_EV;
            S_NEND_RD: n_state = S_NEND_EV;
            S_P1_EV: begin
                if (i_stat.qend) begin
                    o_cmd.set_hit = 1'b1;
                    n_state = S_DONE;
                end else if (i_stat.nend || !i_stat.eq) begin
                    o_cmd.clr_ptr = 1'b1;
                    n_state = S_SKIP_RD;
                end else begin
                    o_cmd.inc_n = 1'b1;
                    o_cmd.inc_q = 1'b1;
                    n_state = S_P1_RD;
                end
            end
            S_SKIP_EV: begin
                o_cmd.inc_n = !i_stat.nend && i_stat.nbl;
                o_cmd.inc_q = !i_stat.qend && i_stat.qbl;
                if (o_cmd.inc_n || o_cmd.inc_q) begin
                    n_state = S_SKIP_RD;
                end else if (i_stat.qend) begin
                    o_cmd.set_hit = 1'b1;
                    n_state = S_DONE;
                end else if (i_stat.nend) begin
                    if (i_stat.ent_last) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.ent_next = 1'b1;
                        n_state = S_ENT;
                    end
                end else begin
                    n_state = S_CMP_RD;
                end
            end
            S_CMP_EV: begin
                if (i_stat.qend || i_stat.qbl) begin
                    n_state = S_NEND_RD;
                end else if (i_stat.nend || i_stat.nbl || !i_stat.eq) begin
                    if (i_stat.ent_last) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.ent_next = 1'b1;
                        n_state = S_ENT;
                    end
                end else begin
                    o_cmd.inc_n = 1'b1;
                    o_cmd.inc_q = 1'b1;
                    n_state = S_CMP_RD;
                end
            end
            S_NEND_EV: begin
                if (!i_stat.nend && !i_stat.nbl) begin
                    o_cmd.inc_n = 1'b1;
                    n_state = S_NEND_RD;
                end else begin
                    n_state = S_SKIP_RD;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[sv/wanm_dp.sv]
// Datapath with the name, length, number and query stores, pointers and result register.
`timescale 1ns / 1ps
module wanm_dp #(
    parameter int MAX_ENTRIES = wanm_pkg::DEF_MAX_ENTRIES,
    parameter int NAME_CHARS  = wanm_pkg::DEF_NAME_CHARS,
    parameter int QUERY_CHARS = wanm_pkg::DEF_QUERY_CHARS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  wanm_pkg::t_cmd                   i_cmd,
    input  logic [1:0]                       i_mode,
    input  logic [7:0]                       i_character,
    input  logic [wanm_pkg::NUM_W-1:0]       i_entry_number,
    input  logic                             i_last,
    input  logic                             i_out_ready,
    output wanm_pkg::t_stat                  o_stat,
    output logic                             o_out_valid,
    output logic [wanm_pkg::OUT_DATA_W-1:0]  o_out_data
);
    import wanm_pkg::*;

    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LW  = $clog2(NAME_CHARS + 1);
    localparam int QLW = $clog2(QUERY_CHARS + 1);
    localparam int QIW = $clog2(QUERY_CHARS);
    localparam int ND  = MAX_ENTRIES * NAME_CHARS;
    localparam int AW  = $clog2(ND);

    logic [7:0]       name_mem  [ND];
    logic [LW-1:0]    len_mem   [MAX_ENTRIES];
    logic [NUM_W-1:0] num_mem   [MAX_ENTRIES];
    logic [7:0]       query_mem [QUERY_CHARS];

    logic [CW-1:0]  r_count;
    logic [LW-1:0]  r_fill;
    logic [QLW-1:0] r_qlen;
    logic [EW-1:0]  r_entry;
    logic [LW-1:0]  r_np;
    logic [QLW-1:0] r_qp;
    logic signed [MATCH_W-1:0] r_res;
    logic           r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [7:0]     r_nch, r_qch;
    logic [LW-1:0]  r_len_rd;
    logic [NUM_W-1:0] r_num_rd;

    logic           name_sel, query_sel, not_full, name_wr, query_wr;
    logic [LW-1:0]  n_fill;
    logic [AW-1:0]  wr_addr, rd_addr;

    assign name_sel  = i_cmd.accept && t_mode'(i_mode) == MODE_NAME;
    assign query_sel = i_cmd.accept && t_mode'(i_mode) == MODE_QUERY;
    assign not_full  = r_count < CW'(MAX_ENTRIES);
    assign name_wr   = name_sel && not_full && i_character != CH_NUL
                       && r_fill < LW'(NAME_CHARS);
    assign query_wr  = query_sel && i_character != CH_NUL
                       && r_qlen < QLW'(QUERY_CHARS);
    assign n_fill    = name_wr ? r_fill + LW'(1) : r_fill;
    assign wr_addr   = AW'(EW'(r_count)) * AW'(NAME_CHARS) + AW'(r_fill);
    assign rd_addr   = AW'(r_entry) * AW'(NAME_CHARS) + AW'(r_np);

    always_ff @(posedge i_clk) begin
        if (name_wr) begin
            name_mem[wr_addr] <= i_character;
        end
        if (name_sel && not_full && i_last) begin
            len_mem[EW'(r_count)] <= n_fill;
            num_mem[EW'(r_count)] <= i_entry_number;
        end
        if (query_wr) begin
            query_mem[r_qlen[QIW-1:0]] <= i_character;
        end
        r_nch    <= name_mem[rd_addr];
        r_qch    <= query_mem[r_qp[QIW-1:0]];
        r_len_rd <= len_mem[r_entry];
        r_num_rd <= num_mem[r_entry];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_fill      <= '0;
            r_qlen      <= '0;
            r_entry     <= '0;
            r_np        <= '0;
            r_qp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (name_sel) begin
                r_fill <= i_last ? '0 : n_fill;
                if (i_last && not_full) begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.accept && t_mode'(i_mode) == MODE_CLEAR) begin
                r_count <= '0;
                r_fill  <= '0;
            end
            if (query_wr) begin
                r_qlen <= r_qlen + QLW'(1);
            end
            if (i_cmd.start_scan || i_cmd.ent_next || i_cmd.clr_ptr) begin
                r_np <= '0;
                r_qp <= '0;
            end else begin
                if (i_cmd.inc_n) begin
                    r_np <= r_np + LW'(1);
                end
                if (i_cmd.inc_q) begin
                    r_qp <= r_qp + QLW'(1);
                end
            end
            if (i_cmd.start_scan) begin
                r_entry <= '0;
            end else if (i_cmd.ent_next) begin
                r_entry <= r_entry + EW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
                r_qlen      <= '0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_scan) begin
            r_res <= NO_MATCH;
        end else if (i_cmd.set_hit) begin
            r_res <= signed'({1'b0, r_num_rd});
        end
        if (i_cmd.load_out) begin
            r_out_data <= {1'b0, LOADED_W'(r_count), r_res};
        end
    end

    always_comb begin
        o_stat.cnt_empty = r_count == '0;
        o_stat.ent_last  = CW'(r_entry) + CW'(1) == r_count;
        o_stat.q_empty   = r_qlen == '0;
        o_stat.nend      = r_np >= r_len_rd;
        o_stat.qend      = r_qp >= r_qlen;
        o_stat.nbl       = is_blank(r_nch);
        o_stat.qbl       = is_blank(r_qch);
        o_stat.eq        = fold(r_nch) == fold(r_qch);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[sv/word_abbreviation_name_matcher.sv]
// Top level of the abbreviation name matcher: controller, datapath and checks.
//
// The input stream carries one character per transfer. tuser holds the mode, tdata
// the character and entry number; tlast closes a name or a query. Mode 0 appends to
// the name being loaded, mode 1 to the query, mode 2 empties the table, mode 3 is ignored.
// Characters are taken one per cycle while the block is idle.
// On the closing query character the table is scanned in load order. Each character
// comparison is a store read state followed by an evaluation state; each entry
// starts with a set-up state, then one read and evaluation pair per character step
// of the prefix pass and of the word walk. Input is not taken during a scan.
// One result transfer follows each query: the number of the first matching entry,
// or -1, together with the count of entries held. It sits in an output register;
// while the receiver stalls, loading carries on, and only the result of the next
// scan waits for the register to drain.
// Reset empties the table and the query and drops any pending result; the stores
// themselves are not cleared, so the block is ready in the first cycle after reset.
`timescale 1ns / 1ps
module word_abbreviation_name_matcher #(
    parameter int MAX_ENTRIES = wanm_pkg::DEF_MAX_ENTRIES,
    parameter int NAME_CHARS  = wanm_pkg::DEF_NAME_CHARS,
    parameter int QUERY_CHARS = wanm_pkg::DEF_QUERY_CHARS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // character [7:0], entry_number [19:8], zero [23:20]
    input  logic [wanm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // mode [1:0]
    input  logic [1:0]                      s_axis_tuser,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // match_number [12:0], entries_loaded [22:13], zero [23]
    output logic [wanm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import wanm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    wanm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_last  (s_axis_tlast),
        .i_mode  (s_axis_tuser),
        .i_stat  (stat),
        .o_ready (s_axis_tready),
        .o_cmd   (cmd)
    );

    wanm_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .NAME_CHARS  (NAME_CHARS),
        .QUERY_CHARS (QUERY_CHARS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_mode         (s_axis_tuser),
        .i_character    (s_axis_tdata[7:0]),
        .i_entry_number (s_axis_tdata[19:8]),
        .i_last         (s_axis_tlast),
        .i_out_ready    (m_axis_tready),
        .o_stat         (stat),
        .o_out_valid    (m_axis_tvalid),
        .o_out_data     (m_axis_tdata)
    );

    a_rise_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.load_out))
        else $error("result appeared without a load");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result register overwritten");

    a_no_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !(cmd.inc_n || cmd.inc_q || cmd.set_hit))
        else $error("scan stepping while idle");

endmodule
